/* rtl/cct_pkg.sv */
// cct_pkg: shared constants for the calorimeter coincidence trigger
// no dependencies; imported by cct_lane, cct_merge and the top level
`default_nettype none

package cct_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int GROUP_A_CHANNELS = 4;
   localparam int HIT_W = 16;
   localparam int ENERGY_W = 13;
   localparam int SLOT_W = 3;
   localparam int TRIG_W = 8;

endpackage

`default_nettype wire

/* rtl/cct_lane.sv */
// cct_lane: one channel of the trigger, keeps the previous hit word and builds
// the stretched slot line over previous plus current frame; uses cct_pkg
`default_nettype none

module cct_lane #(
   parameter int FRAME_SLOTS = 8,
   parameter int STRETCH_SLOTS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [cct_pkg::HIT_W-1:0]         hit,
   input  logic [cct_pkg::ENERGY_W-1:0]      threshold,
   output logic [2*FRAME_SLOTS-1:0]          line
);
   import cct_pkg::*;

   localparam int LINE_W = 2 * FRAME_SLOTS;

   logic [HIT_W-1:0]  prev_word_ff;
   logic [LINE_W-1:0] line_ff;
   logic [LINE_W-1:0] line_in;

   always_comb begin
      logic [ENERGY_W-1:0] prev_energy;
      logic [ENERGY_W-1:0] cur_energy;
      int                  prev_start;
      int                  cur_start;
      logic                prev_counts;
      logic                cur_counts;
      logic                start_taken;
      logic [LINE_W-1:0]   prev_line;
      logic [LINE_W-1:0]   cur_mask;

      prev_energy = prev_word_ff[HIT_W-1:SLOT_W];
      cur_energy  = hit[HIT_W-1:SLOT_W];
      prev_start  = int'(prev_word_ff[SLOT_W-1:0]);
      cur_start   = int'(hit[SLOT_W-1:0]) + FRAME_SLOTS;
      prev_counts = (prev_energy > threshold) && (prev_start < FRAME_SLOTS);
      cur_counts  = (cur_energy > threshold) && (cur_start < LINE_W);

      start_taken = 1'b0;
      for (int i = 0; i < LINE_W; i++) begin
         prev_line[i] = prev_counts && (i >= prev_start) && (i < prev_start + STRETCH_SLOTS);
         cur_mask[i]  = (i >= cur_start) && (i < cur_start + STRETCH_SLOTS);
         if (i == cur_start && prev_line[i]) begin
            start_taken = 1'b1;
         end
      end

      // a current stretch whose start slot is already lit is dropped whole
      line_in = prev_line | ((cur_counts && !start_taken) ? cur_mask : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_word_ff <= '0;
      end else if (accept) begin
         prev_word_ff <= hit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_ff <= line_in;
      end
   end

   assign line = line_ff;

endmodule

`default_nettype wire

/* rtl/cct_merge.sv */
// cct_merge: combines the lane lines into group coincidence and finds the
// rising edges inside the current frame; uses cct_pkg
`default_nettype none

module cct_merge #(
   parameter int FRAME_SLOTS = 8
) (
   input  logic [cct_pkg::NUM_CHANNELS-1:0][2*FRAME_SLOTS-1:0] lines,
   output logic [cct_pkg::TRIG_W-1:0]                          trigger_bits
);
   import cct_pkg::*;

   localparam int LINE_W = 2 * FRAME_SLOTS;

   logic [LINE_W-1:0] grp_a;
   logic [LINE_W-1:0] grp_b;
   logic [LINE_W-1:0] coinc;

   always_comb begin
      grp_a = '0;
      grp_b = '0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         if (ch < GROUP_A_CHANNELS) begin
            grp_a = grp_a | lines[ch];
         end else begin
            grp_b = grp_b | lines[ch];
         end
      end
      coinc = grp_a & grp_b;
   end

   // slot k of the current frame looks back at the slot before it,
   // which for k = 0 is the last slot of the previous frame
   for (genvar k = 0; k < TRIG_W; k++) begin : g_rise
      if (k < FRAME_SLOTS) begin : g_live
         assign trigger_bits[k] = coinc[FRAME_SLOTS+k] & ~coinc[FRAME_SLOTS+k-1];
      end else begin : g_none
         assign trigger_bits[k] = 1'b0;
      end
   end

endmodule

`default_nettype wire

/* rtl/calorimeter_coincidence_trigger_core.sv */
// calorimeter_coincidence_trigger_core: top level, eight channel lanes, merge
// stage, output register and threshold register; uses cct_pkg, cct_lane, cct_merge
`default_nettype none

// Takes one 8-channel hit frame per word and returns one 8-bit trigger word
// per frame, in order. Sustained rate is one frame per clock while rsp_ready
// stays high. From acceptance to rsp_valid a frame passes the lane register,
// which holds each channel's stretched slot line, and then the output
// register behind the merge stage. Each register has its own enable, so a
// new frame is taken into an empty lane register while a finished trigger
// word waits for rsp_ready. Each lane keeps its previous hit word (cleared by
// reset); the energy test on that word uses the threshold in force when the
// next frame arrives. The threshold register accepts a write on any cycle
// (csr_ready is always high) but should be changed only while the pipeline
// is empty. A hit counts when its energy (bits 15:3) is strictly above the
// threshold; its time slot is bits 2:0.
module calorimeter_coincidence_trigger_core #(
   parameter int FRAME_SLOTS = 8,
   parameter int STRETCH_SLOTS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cct_pkg::HIT_W-1:0]         req_chan0_hit,
   input  logic [cct_pkg::HIT_W-1:0]         req_chan1_hit,
   input  logic [cct_pkg::HIT_W-1:0]         req_chan2_hit,
   input  logic [cct_pkg::HIT_W-1:0]         req_chan3_hit,
   input  logic [cct_pkg::HIT_W-1:0]         req_chan4_hit,
   input  logic [cct_pkg::HIT_W-1:0]         req_chan5_hit,
   input  logic [cct_pkg::HIT_W-1:0]         req_chan6_hit,
   input  logic [cct_pkg::HIT_W-1:0]         req_chan7_hit,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cct_pkg::TRIG_W-1:0]        rsp_trigger_bits,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cct_pkg::ENERGY_W-1:0]      csr_energy_threshold
);
   import cct_pkg::*;

   localparam int LINE_W = 2 * FRAME_SLOTS;
   localparam int LIVE_BITS = (FRAME_SLOTS < TRIG_W) ? FRAME_SLOTS : TRIG_W;
   localparam logic [TRIG_W-1:0] LIVE_MASK = TRIG_W'((32'd1 << LIVE_BITS) - 32'd1);

   // threshold register
   logic [ENERGY_W-1:0] threshold_ff;

   // pipeline control
   logic lane_valid_ff;
   logic lane_valid_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic out_free;
   logic lane_move;
   logic accept;

   // data path
   logic [NUM_CHANNELS-1:0][HIT_W-1:0]  hits;
   logic [NUM_CHANNELS-1:0][LINE_W-1:0] lines;
   logic [TRIG_W-1:0]                   merged_bits;
   logic [TRIG_W-1:0]                   trigger_ff;

   assign hits = {req_chan7_hit, req_chan6_hit, req_chan5_hit, req_chan4_hit,
                  req_chan3_hit, req_chan2_hit, req_chan1_hit, req_chan0_hit};

   // output register is empty or is being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign lane_move = lane_valid_ff && out_free;
   assign req_ready = !lane_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      lane_valid_in = accept ? 1'b1 : (lane_move ? 1'b0 : lane_valid_ff);
      out_valid_in  = lane_move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         threshold_ff  <= '0;
      end else begin
         lane_valid_ff <= lane_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_valid) begin
            threshold_ff <= csr_energy_threshold;
         end
      end
   end

   // one lane per channel, each registers its slot line on accept
   for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_lane
      cct_lane #(
         .FRAME_SLOTS   (FRAME_SLOTS),
         .STRETCH_SLOTS (STRETCH_SLOTS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .hit       (hits[ch]),
         .threshold (threshold_ff),
         .line      (lines[ch])
      );
   end

   // group or, coincidence and edge detect
   cct_merge #(
      .FRAME_SLOTS (FRAME_SLOTS)
   ) u_merge (
      .lines        (lines),
      .trigger_bits (merged_bits)
   );

   always_ff @(posedge clock) begin
      if (lane_move) begin
         trigger_ff <= merged_bits;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_trigger_bits = trigger_ff;

   // a word leaving the lane stage lands in the output register
   assert property (@(posedge clock) disable iff (reset) lane_move |=> rsp_valid)
      else $error("lane word lost on its way to the output register");

   // an accepted frame occupies the lane stage next cycle
   assert property (@(posedge clock) disable iff (reset) accept |=> lane_valid_ff)
      else $error("accepted frame missing from the lane stage");

   // input stalls only when both stages are full and the output is held
   assert property (@(posedge clock) disable iff (reset)
                    !req_ready |-> (lane_valid_ff && rsp_valid && !rsp_ready))
      else $error("input stalled with room in the pipeline");

   // slots beyond the frame never fire
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> ((rsp_trigger_bits & ~LIVE_MASK) == '0))
      else $error("trigger bit set beyond the frame");

endmodule

`default_nettype wire

/* test/tb_calorimeter_coincidence_trigger_core.sv */
// tb_calorimeter_coincidence_trigger_core: self-checking testbench for the coincidence trigger
// depends on cct_pkg and calorimeter_coincidence_trigger_core; frames in, trigger words checked
// against an in-bench predictor of the stretch and coincidence logic
module tb_calorimeter_coincidence_trigger_core;
   timeunit 1ns;
   timeprecision 1ps;

   import cct_pkg::*;

   localparam int FRAME_SLOTS = 8;
   localparam int STRETCH_SLOTS = 4;
   // timeline is previous frame in the low half, current frame in the high half
   localparam int LINE_W = 2 * FRAME_SLOTS;
   localparam logic [LINE_W-1:0] STRETCH_ONES = LINE_W'((1 << STRETCH_SLOTS) - 1);
   localparam int CLK_HALF = 4;
   localparam int RESET_CYCLES = 6;
   // two register stages plus a little slack before touching the threshold
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS = 10;
   // the timeout is over ten times the worst slow run
   localparam int TIMEOUT_NS = 2_000_000;

   typedef logic [HIT_W-1:0] hit_word_t;
   typedef logic [NUM_CHANNELS-1:0][HIT_W-1:0] frame_t;
   typedef logic [LINE_W-1:0] slot_line_t;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [HIT_W-1:0] req_chan0_hit, req_chan1_hit, req_chan2_hit, req_chan3_hit;
   logic [HIT_W-1:0] req_chan4_hit, req_chan5_hit, req_chan6_hit, req_chan7_hit;
   logic rsp_valid;
   logic rsp_ready;
   logic [TRIG_W-1:0] rsp_trigger_bits;
   logic csr_valid;
   logic csr_ready;
   logic [ENERGY_W-1:0] csr_energy_threshold;

   // predictor state: threshold in force and last accepted frame
   logic [ENERGY_W-1:0] cur_threshold;
   frame_t prev_frame;

   // trigger words still owed by the block, oldest first
   logic [TRIG_W-1:0] expected_triggers[$];

   int fail_count = 0;
   int report_count = 0;
   bit allow_idle = 1'b1;

   calorimeter_coincidence_trigger_core #(
      .FRAME_SLOTS(FRAME_SLOTS),
      .STRETCH_SLOTS(STRETCH_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_chan0_hit(req_chan0_hit),
      .req_chan1_hit(req_chan1_hit),
      .req_chan2_hit(req_chan2_hit),
      .req_chan3_hit(req_chan3_hit),
      .req_chan4_hit(req_chan4_hit),
      .req_chan5_hit(req_chan5_hit),
      .req_chan6_hit(req_chan6_hit),
      .req_chan7_hit(req_chan7_hit),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_trigger_bits(rsp_trigger_bits),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_energy_threshold(csr_energy_threshold)
   );

   always #(CLK_HALF) clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // energy strictly above threshold and slot inside the frame
   function automatic bit hit_counts(input hit_word_t w);
      return (w[HIT_W-1:SLOT_W] > cur_threshold) && (int'(w[SLOT_W-1:0]) < FRAME_SLOTS);
   endfunction

   // stretch runs off the top of the timeline and is simply lost there
   function automatic slot_line_t stretch_from(input int start);
      return STRETCH_ONES << start;
   endfunction

   // trigger word for one frame; advances the previous-frame copy
   function automatic logic [TRIG_W-1:0] compute_trigger(input frame_t frame);
      slot_line_t line;
      slot_line_t grp_a;
      slot_line_t grp_b;
      slot_line_t coinc;
      slot_line_t rise;
      int start;
      grp_a = '0;
      grp_b = '0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         line = '0;
         if (hit_counts(prev_frame[ch]))
            line |= stretch_from(int'(prev_frame[ch][SLOT_W-1:0]));
         if (hit_counts(frame[ch])) begin
            start = int'(frame[ch][SLOT_W-1:0]) + FRAME_SLOTS;
            // current stretch dropped when its first slot is already covered
            if (!line[start])
               line |= stretch_from(start);
         end
         if (ch < GROUP_A_CHANNELS)
            grp_a |= line;
         else
            grp_b |= line;
      end
      prev_frame = frame;
      coinc = grp_a & grp_b;
      rise = coinc & ~(coinc << 1);
      return rise[FRAME_SLOTS +: TRIG_W];
   endfunction

   // ---------------------------------------------------------------------
   // result side: random stalls and the checker
   // ---------------------------------------------------------------------

   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (allow_idle && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // values read here are the ones present at the edge
   always @(posedge clock) begin : check_trigger_words
      logic [TRIG_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_triggers.size() == 0) begin
            fail_count++;
            if (report_count < MAX_REPORTS)
               $display("unexpected trigger word %02h at %0t", rsp_trigger_bits, $realtime);
            report_count++;
         end else begin
            want = expected_triggers.pop_front();
            if (rsp_trigger_bits !== want) begin
               fail_count++;
               if (report_count < MAX_REPORTS)
                  $display("trigger_bits mismatch: expected %02h, got %02h at %0t",
                           want, rsp_trigger_bits, $realtime);
               report_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic hit_word_t make_hit(input logic [ENERGY_W-1:0] energy,
                                          input logic [SLOT_W-1:0] slot);
      return {energy, slot};
   endfunction

   // energies clustered around the threshold plus both ends of the range
   function automatic logic [ENERGY_W-1:0] pick_energy();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return cur_threshold;
         3: return cur_threshold + 1'b1;
         4: return cur_threshold - 1'b1;
         5: return ENERGY_W'($urandom);
         default: return ENERGY_W'($urandom_range(int'(cur_threshold), (1 << ENERGY_W) - 1));
      endcase
   endfunction

   // mostly well-formed hits, some raw noise words and some whole noise frames
   function automatic frame_t random_frame();
      frame_t f;
      bit noise;
      noise = ($urandom_range(0, 9) == 0);
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         if (noise || $urandom_range(0, 7) == 0)
            f[ch] = HIT_W'($urandom);
         else if ($urandom_range(0, 4) == 0)
            f[ch] = make_hit(ENERGY_W'($urandom_range(0, int'(cur_threshold))),
                             SLOT_W'($urandom));
         else
            f[ch] = make_hit(pick_energy(), SLOT_W'($urandom));
      end
      return f;
   endfunction

   // valid stays up between back-to-back words; it only drops for a gap or
   // when the pipeline is drained
   task automatic send_frame(input frame_t f);
      if (allow_idle && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_chan0_hit <= f[0];
      req_chan1_hit <= f[1];
      req_chan2_hit <= f[2];
      req_chan3_hit <= f[3];
      req_chan4_hit <= f[4];
      req_chan5_hit <= f[5];
      req_chan6_hit <= f[6];
      req_chan7_hit <= f[7];
      do @(posedge clock); while (!req_ready);
      expected_triggers.push_back(compute_trigger(f));
   endtask

   // called in the step of the last acceptance, so valid drops right there
   task automatic wait_pipeline_empty();
      req_valid <= 1'b0;
      while (expected_triggers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [ENERGY_W-1:0] value);
      wait_pipeline_empty();
      csr_valid <= 1'b1;
      csr_energy_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      cur_threshold = value;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset threshold of zero: energy 1 counts, energy 0 does not
   task automatic test_basic_coincidence();
      frame_t f;
      f = '0;
      f[0] = make_hit(1, 0);
      f[4] = make_hit(1, 0);
      send_frame(f);
      send_frame('0);
      f = '0;
      f[0] = make_hit(0, 0);
      f[4] = make_hit(1, 0);
      send_frame(f);
      // every bit set: top energy, last slot, stretch cut at end of frame
      send_frame('1);
      // previous slot-7 hits carry across the boundary, no new rise at slot 0
      send_frame('0);
      wait_pipeline_empty();
   endtask

   task automatic test_stretch_edges();
      frame_t f;
      // group a stretch cut at the end, group b elsewhere: no overlap
      f = '0;
      f[1] = make_hit(5, 6);
      f[5] = make_hit(5, 2);
      send_frame(f);
      // chan1 start slot already covered by its previous stretch, so skipped;
      // if it were stretched it would meet chan5 and fire
      f = '0;
      f[1] = make_hit(5, 1);
      f[5] = make_hit(5, 3);
      send_frame(f);
      // two hits in the same group never coincide
      f = '0;
      f[0] = make_hit(9, 0);
      f[2] = make_hit(9, 0);
      send_frame(f);
      // two separate rises in one frame
      f = '0;
      f[0] = make_hit(9, 0);
      f[4] = make_hit(9, 0);
      f[1] = make_hit(9, 5);
      f[6] = make_hit(9, 5);
      send_frame(f);
      // coincidence from the previous frame running on into slot 0
      f = '0;
      f[3] = make_hit(9, 6);
      f[7] = make_hit(9, 5);
      send_frame(f);
      f = '0;
      f[3] = make_hit(9, 0);
      f[7] = make_hit(9, 1);
      send_frame(f);
      wait_pipeline_empty();
   endtask

   task automatic test_threshold_extremes();
      frame_t f;
      // top threshold: nothing can count
      write_threshold('1);
      send_frame('1);
      send_frame('1);
      // one below top: only the maximum energy counts
      write_threshold({ENERGY_W{1'b1}} - 1'b1);
      f = '0;
      f[0] = make_hit('1, 2);
      f[4] = make_hit({ENERGY_W{1'b1}} - 1'b1, 2);
      send_frame(f);
      f = '0;
      f[0] = make_hit('1, 2);
      f[4] = make_hit('1, 4);
      send_frame(f);
      write_threshold('0);
      send_frame('1);
      send_frame('0);
      wait_pipeline_empty();
   endtask

   task automatic run_random_phase(input logic [ENERGY_W-1:0] threshold, input int count);
      write_threshold(threshold);
      repeat (count) send_frame(random_frame());
      wait_pipeline_empty();
   endtask

   task automatic test_random_frames();
      run_random_phase('1, 40);
      run_random_phase(ENERGY_W'($urandom_range(0, 63)), 120);
      run_random_phase(ENERGY_W'($urandom), 100);
      run_random_phase('0, 120);
      // last stretch runs at full rate on both sides
      allow_idle = 1'b0;
      run_random_phase(ENERGY_W'($urandom_range(0, 1023)), 120);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_chan0_hit <= '0;
      req_chan1_hit <= '0;
      req_chan2_hit <= '0;
      req_chan3_hit <= '0;
      req_chan4_hit <= '0;
      req_chan5_hit <= '0;
      req_chan6_hit <= '0;
      req_chan7_hit <= '0;
      csr_valid <= 1'b0;
      csr_energy_threshold <= '0;
      cur_threshold = '0;
      prev_frame = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_basic_coincidence();
      test_stretch_edges();
      test_threshold_extremes();
      test_random_frames();

      wait_pipeline_empty();
      if (expected_triggers.size() != 0)
         fail_count++;
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
